### sv/day_window_thermostat_with_run_timers_core_assert.svh
// Assertion macros for the thermostat core.
`ifndef DAY_WINDOW_THERMOSTAT_WITH_RUN_TIMERS_CORE_ASSERT_SVH
`define DAY_WINDOW_THERMOSTAT_WITH_RUN_TIMERS_CORE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define DWT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define DWT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dwt_pkg.sv
// Types and constants for the day-window thermostat core.
package dwt_pkg;

  localparam int unsigned MinuteW  = 11;
  localparam int unsigned TempW    = 12;
  localparam int unsigned SecondsW = 32;
  localparam int unsigned SpeedW   = 7;
  localparam int unsigned FanMinW  = 10;
  localparam int unsigned MistSecW = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SpeedW-1:0] SpeedMax = SpeedW'(100);

  // Register reset values
  localparam logic [MinuteW-1:0]      SunriseRst   = MinuteW'(360);
  localparam logic [MinuteW-1:0]      SunsetRst    = MinuteW'(1080);
  localparam logic signed [TempW-1:0] TargetDayRst = TempW'(400);
  localparam logic signed [TempW-1:0] TargetNgtRst = TempW'(400);
  localparam logic signed [TempW-1:0] LampLimitRst = TempW'(800);
  localparam logic [FanMinW-1:0]      FanMinRst    = FanMinW'(120);
  localparam logic [SpeedW-1:0]       FanSpeedRst  = SpeedW'(60);
  localparam logic [MistSecW-1:0]     MistSecRst   = MistSecW'(120);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SUNRISE      = 4'd0,
    REG_SUNSET       = 4'd1,
    REG_TARGET_DAY   = 4'd2,
    REG_TARGET_NIGHT = 4'd3,
    REG_LAMP_LIMIT   = 4'd4,
    REG_FAN_MINUTES  = 4'd5,
    REG_FAN_SPEED    = 4'd6,
    REG_MIST_SECONDS = 4'd7
  } dwt_reg_e;

  typedef struct packed {
    logic [MinuteW-1:0]      day_open_minute;
    logic [MinuteW-1:0]      day_close_minute;
    logic signed [TempW-1:0] target_day;
    logic signed [TempW-1:0] target_night;
    logic signed [TempW-1:0] lamp_limit;
    logic [FanMinW-1:0]      fan_run_minutes;
    logic [SpeedW-1:0]       fan_run_speed;
    logic [MistSecW-1:0]     mist_run_seconds;
  } dwt_cfg_t;

  typedef struct packed {
    logic [MinuteW-1:0]      minute_of_day;
    logic [SecondsW-1:0]     now_seconds;
    logic signed [TempW-1:0] platform_temp;
    logic                    platform_valid;
    logic signed [TempW-1:0] lamp_temp;
    logic                    lamp_valid;
  } dwt_in_t;

  typedef struct packed {
    logic              heater_on;
    logic              lights_on;
    logic [SpeedW-1:0] fan_speed;
    logic              mister_on;
    logic              day_now;
    logic              sunrise_event;
    logic              sunset_event;
  } dwt_out_t;

  typedef struct packed {
    logic                prev_day;
    logic                primed;
    logic                heater_level;
    logic [SpeedW-1:0]   fan_level;
    logic [SecondsW-1:0] fan_deadline;
    logic                fan_armed;
    logic                mister_level;
    logic [SecondsW-1:0] mist_deadline;
    logic                mist_armed;
  } dwt_state_t;

  localparam dwt_state_t StateRst = '0;

endpackage

### sv/dwt_step.sv
// Per-tick control logic: day window, heater, run timers and next state.
module dwt_step import dwt_pkg::*; (
  input  dwt_cfg_t   cfg_i,
  input  dwt_in_t    word_i,
  input  dwt_state_t state_i,
  output dwt_state_t state_o,
  output dwt_out_t   word_o
);

  logic                  day;
  logic                  prev;
  logic                  rise;
  logic                  fall;
  logic                  want;
  logic signed [TempW-1:0] target;
  logic [MistSecW-1:0]   fan_secs;
  logic [SecondsW:0]     fan_sum;
  logic [SecondsW:0]     mist_sum;
  logic [SecondsW-1:0]   fan_sat;
  logic [SecondsW-1:0]   mist_sat;
  dwt_state_t            nx;

  always_comb begin
    if (cfg_i.day_open_minute < cfg_i.day_close_minute) begin
      day = (word_i.minute_of_day >= cfg_i.day_open_minute) &&
            (word_i.minute_of_day <  cfg_i.day_close_minute);
    end else begin
      day = (word_i.minute_of_day >= cfg_i.day_open_minute) ||
            (word_i.minute_of_day <  cfg_i.day_close_minute);
    end
  end

  // first tick sees no edge
  assign prev = state_i.primed ? state_i.prev_day : day;
  assign rise = day & ~prev;
  assign fall = ~day & prev;

  assign target = day ? cfg_i.target_day : cfg_i.target_night;
  assign want   = (word_i.platform_temp < target) &&
                  !(word_i.lamp_valid && (word_i.lamp_temp > cfg_i.lamp_limit));

  // minutes * 60 = m*64 - m*4
  assign fan_secs = {cfg_i.fan_run_minutes, 6'b0} - {4'b0, cfg_i.fan_run_minutes, 2'b0};
  assign fan_sum  = {1'b0, word_i.now_seconds} + (SecondsW+1)'(fan_secs);
  assign mist_sum = {1'b0, word_i.now_seconds} + (SecondsW+1)'(cfg_i.mist_run_seconds);
  assign fan_sat  = fan_sum[SecondsW]  ? '1 : fan_sum[SecondsW-1:0];
  assign mist_sat = mist_sum[SecondsW] ? '1 : mist_sum[SecondsW-1:0];

  always_comb begin
    nx          = state_i;
    nx.primed   = 1'b1;
    nx.prev_day = day;
    if (word_i.platform_valid) begin
      nx.heater_level = want;
    end
    if (rise) begin
      nx.fan_deadline = fan_sat;
      nx.fan_armed    = 1'b1;
      nx.fan_level    = (cfg_i.fan_run_speed > SpeedMax) ? SpeedMax : cfg_i.fan_run_speed;
    end
    if (fall) begin
      nx.mist_deadline = mist_sat;
      nx.mist_armed    = 1'b1;
      nx.mister_level  = 1'b1;
    end
    if (nx.fan_armed && (word_i.now_seconds >= nx.fan_deadline)) begin
      nx.fan_level    = '0;
      nx.fan_armed    = 1'b0;
      nx.fan_deadline = '0;
    end
    if (nx.mist_armed && (word_i.now_seconds >= nx.mist_deadline)) begin
      nx.mister_level  = 1'b0;
      nx.mist_armed    = 1'b0;
      nx.mist_deadline = '0;
    end
  end

  assign state_o = nx;

  assign word_o.heater_on     = nx.heater_level;
  assign word_o.lights_on     = day;
  assign word_o.fan_speed     = nx.fan_level;
  assign word_o.mister_on     = nx.mister_level;
  assign word_o.day_now       = day;
  assign word_o.sunrise_event = rise;
  assign word_o.sunset_event  = fall;

endmodule

### sv/day_window_thermostat_with_run_timers_core.sv
// Top level of the day-window thermostat core with timed fan and mister runs.
// Each input word is one control tick and yields exactly one result word. A tick
// lands in an input register; the control logic (day window, heater compare,
// fan and mister deadlines, 33-bit saturating add and 32-bit compare) then runs
// on it and its result is captured in the output register together with the
// controller state once the output register is free. One word is taken every
// cycle while the output side keeps draining. A held result stalls the input
// only once the input register is also full, so up to two ticks can wait.
// Configuration writes are always accepted (cfg_ready_o is tied high) and must
// only happen while no tick is in flight; indexes above 7 are ignored. After
// reset the registers hold their defaults (day 06:00 to 18:00, both targets
// 25 C, lamp limit 50 C, fan 120 min at 60 %, mister 120 s). Temperatures are
// signed 1/16 C.
module day_window_thermostat_with_run_timers_core import dwt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dwt_in_t             in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dwt_out_t            out_word_o
);

`include "day_window_thermostat_with_run_timers_core_assert.svh"

  dwt_cfg_t   cfg_q;
  dwt_in_t    in_q;
  logic       in_valid_q;
  dwt_state_t state_q, state_d;
  dwt_out_t   out_q, out_d;
  logic       out_valid_q;
  logic       out_free;
  logic       step_fire;

  // Config writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.day_open_minute  <= SunriseRst;
      cfg_q.day_close_minute <= SunsetRst;
      cfg_q.target_day       <= TargetDayRst;
      cfg_q.target_night     <= TargetNgtRst;
      cfg_q.lamp_limit       <= LampLimitRst;
      cfg_q.fan_run_minutes  <= FanMinRst;
      cfg_q.fan_run_speed    <= FanSpeedRst;
      cfg_q.mist_run_seconds <= MistSecRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SUNRISE:      cfg_q.day_open_minute  <= cfg_data_i[MinuteW-1:0];
        REG_SUNSET:       cfg_q.day_close_minute <= cfg_data_i[MinuteW-1:0];
        REG_TARGET_DAY:   cfg_q.target_day       <= $signed(cfg_data_i[TempW-1:0]);
        REG_TARGET_NIGHT: cfg_q.target_night     <= $signed(cfg_data_i[TempW-1:0]);
        REG_LAMP_LIMIT:   cfg_q.lamp_limit       <= $signed(cfg_data_i[TempW-1:0]);
        REG_FAN_MINUTES:  cfg_q.fan_run_minutes  <= cfg_data_i[FanMinW-1:0];
        REG_FAN_SPEED:    cfg_q.fan_run_speed    <= cfg_data_i[SpeedW-1:0];
        REG_MIST_SECONDS: cfg_q.mist_run_seconds <= cfg_data_i[MistSecW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: output register frees when empty or being taken
  assign out_free   = !out_valid_q || out_ready_i;
  assign step_fire  = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

  dwt_step u_step (
    .cfg_i   (cfg_q),
    .word_i  (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .word_o  (out_d)
  );

  // Controller state moves only on a processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `DWT_ASSERT_IMP(a_one_edge, out_valid_o, !(out_word_o.sunrise_event && out_word_o.sunset_event), "both day edges in one word")
  `DWT_ASSERT_IMP(a_rise_is_day, out_valid_o && out_word_o.sunrise_event, out_word_o.day_now, "sunrise outside day")
  `DWT_ASSERT_IMP(a_fan_idle, !state_q.fan_armed, state_q.fan_level == '0, "fan running without a run")
  `DWT_ASSERT_IMP(a_mist_idle, !state_q.mist_armed, !state_q.mister_level, "mister on without a run")
  `DWT_ASSERT_NXT(a_step_out, step_fire, out_valid_o && state_q.primed, "processed tick lost")

endmodule

### test/dwt_tick_checker.sv
// Scoreboard for the thermostat core: mirrors its tick logic and checks every result word.
`timescale 1ns / 100ps
module dwt_tick_checker import dwt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  dwt_in_t             in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  dwt_out_t            out_word_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  sunrise_seen_o,
  output int                  sunset_seen_o
);

  localparam int MaxReports = 10;
  localparam int SecsPerMin = 60;

  // register mirror
  logic [MinuteW-1:0]      rise_min;
  logic [MinuteW-1:0]      set_min;
  logic signed [TempW-1:0] tgt_day;
  logic signed [TempW-1:0] tgt_night;
  logic signed [TempW-1:0] lamp_max;
  logic [FanMinW-1:0]      fan_mins;
  logic [SpeedW-1:0]       fan_pct;
  logic [MistSecW-1:0]     mist_secs;

  // controller state mirror
  logic                day_q;
  logic                primed_q;
  logic                heat_q;
  logic [SpeedW-1:0]   fan_q;
  logic [SecondsW-1:0] fan_due;
  logic                fan_run;
  logic                mist_q;
  logic [SecondsW-1:0] mist_due;
  logic                mist_run;

  dwt_out_t tick_q[$];
  dwt_out_t want;
  logic     bad;

  function automatic logic in_window(logic [MinuteW-1:0] m);
    if (rise_min < set_min) return (m >= rise_min) && (m < set_min);
    return (m >= rise_min) || (m < set_min);
  endfunction

  function automatic logic [SecondsW-1:0] add_sat(logic [SecondsW-1:0] a,
                                                  logic [SecondsW:0] b);
    logic [SecondsW:0] s;
    s = {1'b0, a} + b;
    return s[SecondsW] ? '1 : s[SecondsW-1:0];
  endfunction

  function automatic dwt_out_t advance_tick(dwt_in_t w);
    dwt_out_t r;
    logic day;
    logic rise;
    logic fall;
    logic want_heat;
    logic signed [TempW-1:0] goal;
    day = in_window(w.minute_of_day);
    // first tick only primes the edge detector
    if (!primed_q) begin
      day_q = day;
      primed_q = 1'b1;
    end
    if (w.platform_valid) begin
      goal = day ? tgt_day : tgt_night;
      want_heat = $signed(w.platform_temp) < goal;
      if (w.lamp_valid && ($signed(w.lamp_temp) > lamp_max)) want_heat = 1'b0;
      heat_q = want_heat;
    end
    rise = day && !day_q;
    fall = !day && day_q;
    if (rise) begin
      fan_due = add_sat(w.now_seconds, (SecondsW+1)'(fan_mins) * SecsPerMin);
      fan_run = 1'b1;
      fan_q   = (fan_pct > SpeedMax) ? SpeedMax : fan_pct;
    end
    if (fall) begin
      mist_due = add_sat(w.now_seconds, (SecondsW+1)'(mist_secs));
      mist_run = 1'b1;
      mist_q   = 1'b1;
    end
    if (fan_run && (w.now_seconds >= fan_due)) begin
      fan_q   = '0;
      fan_run = 1'b0;
      fan_due = '0;
    end
    if (mist_run && (w.now_seconds >= mist_due)) begin
      mist_q   = 1'b0;
      mist_run = 1'b0;
      mist_due = '0;
    end
    day_q = day;
    r.heater_on     = heat_q;
    r.lights_on     = day;
    r.fan_speed     = fan_q;
    r.mister_on     = mist_q;
    r.day_now       = day;
    r.sunrise_event = rise;
    r.sunset_event  = fall;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_min  = SunriseRst;
      set_min   = SunsetRst;
      tgt_day   = TargetDayRst;
      tgt_night = TargetNgtRst;
      lamp_max  = LampLimitRst;
      fan_mins  = FanMinRst;
      fan_pct   = FanSpeedRst;
      mist_secs = MistSecRst;
      day_q    = 1'b0;
      primed_q = 1'b0;
      heat_q   = 1'b0;
      fan_q    = '0;
      fan_due  = '0;
      fan_run  = 1'b0;
      mist_q   = 1'b0;
      mist_due = '0;
      mist_run = 1'b0;
      tick_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      checked_o      = 0;
      sunrise_seen_o = 0;
      sunset_seen_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SUNRISE:      rise_min  = cfg_data_i[MinuteW-1:0];
          REG_SUNSET:       set_min   = cfg_data_i[MinuteW-1:0];
          REG_TARGET_DAY:   tgt_day   = cfg_data_i[TempW-1:0];
          REG_TARGET_NIGHT: tgt_night = cfg_data_i[TempW-1:0];
          REG_LAMP_LIMIT:   lamp_max  = cfg_data_i[TempW-1:0];
          REG_FAN_MINUTES:  fan_mins  = cfg_data_i[FanMinW-1:0];
          REG_FAN_SPEED:    fan_pct   = cfg_data_i[SpeedW-1:0];
          REG_MIST_SECONDS: mist_secs = cfg_data_i[MistSecW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) tick_q.push_back(advance_tick(in_word_i));
      if (out_valid_i && out_ready_i) begin
        if (tick_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports)
            $display("result word with no tick outstanding: %p", out_word_i);
        end else begin
          want = tick_q.pop_front();
          bad = (out_word_i.heater_on     !== want.heater_on)     ||
                (out_word_i.lights_on     !== want.lights_on)     ||
                (out_word_i.fan_speed     !== want.fan_speed)     ||
                (out_word_i.mister_on     !== want.mister_on)     ||
                (out_word_i.day_now       !== want.day_now)       ||
                (out_word_i.sunrise_event !== want.sunrise_event) ||
                (out_word_i.sunset_event  !== want.sunset_event);
          if (bad) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports) begin
              $display("word %0d exp: heat %b light %b fan %0d mist %b day %b rise %b set %b",
                       checked_o, want.heater_on, want.lights_on, want.fan_speed,
                       want.mister_on, want.day_now, want.sunrise_event, want.sunset_event);
              $display("word %0d got: heat %b light %b fan %0d mist %b day %b rise %b set %b",
                       checked_o, out_word_i.heater_on, out_word_i.lights_on,
                       out_word_i.fan_speed, out_word_i.mister_on, out_word_i.day_now,
                       out_word_i.sunrise_event, out_word_i.sunset_event);
            end
          end
          if (want.sunrise_event) sunrise_seen_o++;
          if (want.sunset_event) sunset_seen_o++;
          checked_o++;
        end
      end
      pending_o = tick_q.size();
    end
  end

endmodule

### test/day_window_thermostat_with_run_timers_core_tb.sv
// Testbench top for the thermostat core: drives ticks and register writes, gives the verdict.
`timescale 1ns / 100ps
module day_window_thermostat_with_run_timers_core_tb;
  import dwt_pkg::*;

  localparam int IdlePct     = 11;   // chance of a bubble on either side, per cent
  localparam int Settle      = 8;    // cycles allowed past the last result
  localparam int RandPhases  = 6;
  localparam int PhaseHalf   = 60;   // ticks between forced drains in a random phase
  localparam int FixedTicks  = 60;
  localparam int WalkMinutes = 1440;

  // indexes the core must ignore
  localparam logic [CfgIdxW-1:0] RegUnusedLo = CfgIdxW'(REG_MIST_SECONDS) + 1'b1;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  dwt_in_t             in_word_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  dwt_out_t            out_word_o;

  int n_fail;
  int n_pending;
  int n_checked;
  int n_rise;
  int n_set;
  int n_writes = 0;

  // calm: no bubbles on either side while set
  logic calm = 1'b0;

  // walking time of day and wall clock for the well-formed tick stream
  int           walk_min = 0;
  logic [31:0]  walk_sec = '0;
  // last targets written, used to centre the temperature readings
  int           td_set   = 400;
  int           tn_set   = 400;
  int           lamp_set = 800;

  day_window_thermostat_with_run_timers_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  dwt_tick_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_word_i      (in_word_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_word_i     (out_word_o),
    .fail_count_o   (n_fail),
    .pending_o      (n_pending),
    .checked_o      (n_checked),
    .sunrise_seen_o (n_rise),
    .sunset_seen_o  (n_set)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: random back-pressure, none while calm.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IdlePct);
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #400us;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic dwt_in_t tick_word(int minute, logic [31:0] secs, int plat,
                                        logic plat_ok, int lamp, logic lamp_ok);
    dwt_in_t w;
    w.minute_of_day  = MinuteW'(minute);
    w.now_seconds    = secs;
    w.platform_temp  = TempW'(plat);
    w.platform_valid = plat_ok;
    w.lamp_temp      = TempW'(lamp);
    w.lamp_valid     = lamp_ok;
    return w;
  endfunction

  // Keeps the field bits, and half the time fills the unused upper bits with junk
  // so that the core's truncation is exercised.
  function automatic logic [CfgDataW-1:0] with_junk(int val, int unsigned width);
    logic [CfgDataW-1:0] keep;
    keep = (CfgDataW'(1) << width) - 1'b1;
    if ($urandom_range(1) == 0) return CfgDataW'(val) & keep;
    return (CfgDataW'($urandom) & ~keep) | (CfgDataW'(val) & keep);
  endfunction

  // Next tick of the stream: mostly a plausible advance of the clock with readings near
  // the targets, now and then a jump near the top of the seconds range or a wholly
  // random word (minutes past 1439, temperatures out of the sensor range).
  function automatic dwt_in_t next_word();
    dwt_in_t     w;
    logic [95:0] raw;
    int          step;
    int          centre;
    if ($urandom_range(99) < 8) begin
      raw = {$urandom, $urandom, $urandom};
      w = raw[$bits(dwt_in_t)-1:0];
      return w;
    end
    step = $urandom_range(90);
    walk_min = (walk_min + step) % WalkMinutes;
    if ($urandom_range(49) == 0) walk_sec = 32'hFFFF_FFFF - $urandom_range(20000);
    else if ($urandom_range(39) == 0) walk_sec = $urandom;
    else walk_sec = walk_sec + step * 60 + $urandom_range(59);
    centre = ($urandom_range(1) == 0) ? td_set : tn_set;
    return tick_word(walk_min, walk_sec,
                     centre + int'($urandom_range(64)) - 32, $urandom_range(99) < 85,
                     lamp_set + int'($urandom_range(64)) - 32, $urandom_range(99) < 85);
  endfunction

  // Offer one tick word; valid then stays up until the word is taken.
  task automatic send_tick(input dwt_in_t w);
    while (!calm && ($urandom_range(99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold off the sender until every tick in flight has produced its word.
  task automatic drain_ticks();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic run_ticks(input int count);
    repeat (count) send_tick(next_word());
    drain_ticks();
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    n_writes++;
  endtask

  task automatic write_all(input int sr, input int ss, input int td, input int tn,
                           input int lamp, input int fan_min, input int speed,
                           input int mist);
    td_set   = td;
    tn_set   = tn;
    lamp_set = lamp;
    write_reg(REG_SUNRISE,      with_junk(sr, MinuteW));
    write_reg(REG_SUNSET,       with_junk(ss, MinuteW));
    write_reg(REG_TARGET_DAY,   with_junk(td, TempW));
    write_reg(REG_TARGET_NIGHT, with_junk(tn, TempW));
    write_reg(REG_LAMP_LIMIT,   with_junk(lamp, TempW));
    write_reg(REG_FAN_MINUTES,  with_junk(fan_min, FanMinW));
    write_reg(REG_FAN_SPEED,    with_junk(speed, SpeedW));
    write_reg(REG_MIST_SECONDS, with_junk(mist, MistSecW));
  endtask

  // Random settings: mostly sensible, now and then anywhere in the field's range.
  task automatic random_setup();
    int sr;
    int ss;
    int td;
    int tn;
    int fan_min;
    int mist;
    sr = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1439);
    ss = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1439);
    if ($urandom_range(7) == 0) ss = sr;
    td = ($urandom_range(7) == 0) ? int'($urandom_range(4095)) - 2048
                                  : int'($urandom_range(800)) - 100;
    tn = ($urandom_range(7) == 0) ? int'($urandom_range(4095)) - 2048
                                  : int'($urandom_range(800)) - 100;
    fan_min = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(240);
    mist    = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(900);
    write_all(sr, ss, td, tn, td + int'($urandom_range(600)), fan_min,
              $urandom_range(127), mist);
    if ($urandom_range(2) == 0) write_reg(RegUnusedLo, CfgDataW'($urandom));
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Writes to indexes past the last register must leave the defaults alone,
    // which the directed ticks below rely on.
    write_reg(RegUnusedLo, CfgDataW'($urandom));
    write_reg(RegUnusedHi, CfgDataW'($urandom));

    // Directed ticks at the reset settings: day 360..1080, targets 400, lamp limit 800,
    // fan 120 min at 60 %, mister 120 s.
    // First tick lands in the day: only primes the edge detector, no sunrise.
    send_tick(tick_word(600, 1000, 0, 1'b1, 0, 1'b1));
    // sunset on the boundary minute; hot lamp forces the heater off despite a cold platform
    send_tick(tick_word(1080, 1010, -2048, 1'b1, 2047, 1'b1));
    // platform reading invalid: heater holds, mister one second short of its deadline
    send_tick(tick_word(1439, 1129, 0, 1'b0, 0, 1'b0));
    // mister stops on its deadline; lamp exactly at the limit does not force off
    send_tick(tick_word(0, 1130, 399, 1'b1, 800, 1'b1));
    // platform equal to target: heater off; lamp invalid
    send_tick(tick_word(359, 1200, 400, 1'b1, 801, 1'b0));
    // sunrise on the boundary minute starts the fan
    send_tick(tick_word(360, 2000, 2047, 1'b1, 801, 1'b1));
    send_tick(tick_word(1079, 9199, -880, 1'b1, 801, 1'b1));
    // fan deadline reached
    send_tick(tick_word(1079, 9200, -880, 1'b1, -2048, 1'b1));
    // minute above 1439 is night: sunset near the top of the seconds range, deadline saturates
    send_tick(tick_word(2047, 32'hFFFF_FFF0, 2000, 1'b1, 0, 1'b0));
    send_tick(tick_word(1500, 32'hFFFF_FFFE, -1, 1'b1, 2047, 1'b0));
    send_tick(tick_word(1440, 32'hFFFF_FFFF, -2048, 1'b0, -2048, 1'b1));
    // saturated fan deadline, then a wrapped seconds count which must not stop it
    send_tick(tick_word(360, 32'hFFFF_FF00, 1000, 1'b1, 500, 1'b1));
    send_tick(tick_word(700, 0, 100, 1'b1, 0, 1'b0));
    send_tick(tick_word(720, 32'hFFFF_FFFF, 0, 1'b0, 0, 1'b0));
    // sunset, then sunrise while the mister still runs
    send_tick(tick_word(1080, 5000, 300, 1'b1, 0, 1'b1));
    send_tick(tick_word(1200, 5050, 500, 1'b1, 0, 1'b1));
    send_tick(tick_word(360, 5060, 300, 1'b1, 900, 1'b1));
    // sunset again during the mister run restarts it
    send_tick(tick_word(1080, 5100, 300, 1'b0, 900, 1'b1));
    // sunrise during a running fan restarts the fan
    send_tick(tick_word(360, 5110, 2000, 1'b1, 0, 1'b1));
    send_tick(tick_word(1000, 5230, -880, 1'b1, 0, 1'b1));
    drain_ticks();

    // Fixed extreme settings.
    // Window wrapping past midnight, lowest day target and lamp limit, highest night
    // target, zero run lengths, fan speed above 100.
    write_all(1320, 300, -2048, 2047, -2048, 0, 127, 0);
    run_ticks(FixedTicks);
    // Equal sunrise and sunset (always day), longest runs.
    write_all(700, 700, 2000, -880, 2047, 1023, 127, 65535);
    run_ticks(FixedTicks);
    // Widest ordinary window, shortest non-zero runs, fan speed zero.
    write_all(0, 2047, 0, 0, 0, 1, 0, 1);
    run_ticks(FixedTicks);

    // Random settings; each phase drains half way so the sender also waits out
    // the whole pipeline mid-phase. One phase runs without any bubbles.
    for (int p = 0; p < RandPhases; p++) begin
      random_setup();
      calm = (p == 2);
      run_ticks(PhaseHalf);
      run_ticks(PhaseHalf);
      calm = 1'b0;
    end

    drain_ticks();
    $display("Checked %0d result words across %0d register writes and %0d settings;",
             n_checked, n_writes, RandPhases + 4);
    $display("the stream crossed %0d sunrise and %0d sunset edges.", n_rise, n_set);
    if ((n_fail == 0) && (n_pending == 0)) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
